@@ sv/cft_pkg.sv @@
`default_nettype none

package cft_pkg;

    // Action codes
    typedef enum logic [1:0] {
        ACT_ROT_IN  = 2'd0,
        ACT_ROT_OUT = 2'd1,
        ACT_PT_IN   = 2'd2,
        ACT_PT_OUT  = 2'd3
    } cft_action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] vin_x;
        logic signed [31:0] vin_y;
        logic signed [31:0] vin_z;
    } cft_item_t;

    // Quotient bits of a normalized component (value never exceeds 2^30)
    localparam int CFT_QW = 31;

endpackage

`default_nettype wire

@@ sv/cft_in_if.sv @@
`default_nettype none

interface cft_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] vin_x;
    logic signed [31:0] vin_y;
    logic signed [31:0] vin_z;

    modport source (
        output valid, action, center_x, center_y, center_z, vin_x, vin_y, vin_z,
        input  ready
    );
    modport sink (
        input  valid, action, center_x, center_y, center_z, vin_x, vin_y, vin_z,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/cft_out_if.sv @@
`default_nettype none

interface cft_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vout_x;
    logic signed [31:0] vout_y;
    logic signed [31:0] vout_z;

    modport source (
        output valid, vout_x, vout_y, vout_z,
        input  ready
    );
    modport sink (
        input  valid, vout_x, vout_y, vout_z,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/cft_isqrt.sv @@
`default_nettype none

// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
module cft_isqrt #(
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_rad,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [PW-1:0] out_pay
);

    localparam int Steps = 32;

    logic          vld_reg  [Steps];
    logic [63:0]   rad_reg  [Steps];
    logic [63:0]   root_reg [Steps];
    logic [PW-1:0] pay_reg  [Steps];

    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * k);
        logic          vld_q;
        logic [63:0]   rad_q;
        logic [63:0]   root_q;
        logic [PW-1:0] pay_q;
        logic [63:0]   trial;

        if (k == 0) begin : g_first
            assign vld_q  = in_valid;
            assign rad_q  = in_rad;
            assign root_q = '0;
            assign pay_q  = in_pay;
        end else begin : g_next
            assign vld_q  = vld_reg[k-1];
            assign rad_q  = rad_reg[k-1];
            assign root_q = root_reg[k-1];
            assign pay_q  = pay_reg[k-1];
        end

        assign trial = root_q + StepBit;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_q;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rad_q >= trial)
                begin
                    rad_reg[k]  <= rad_q - trial;
                    root_reg[k] <= (root_q >> 1) + StepBit;
                end
                else
                begin
                    rad_reg[k]  <= rad_q;
                    root_reg[k] <= root_q >> 1;
                end
                pay_reg[k] <= pay_q;
            end
        end
    end

    assign out_valid = vld_reg[Steps-1];
    assign out_root  = root_reg[Steps-1][31:0];
    assign out_pay   = pay_reg[Steps-1];

endmodule

`default_nettype wire

@@ sv/cft_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
// The caller guarantees the quotient fits in CFT_QW bits.
module cft_div import cft_pkg::*; #(
    parameter int PW    = 8,
    parameter int LANES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_num [LANES],
    input  logic [31:0]       in_den,
    input  logic [PW-1:0]     in_pay,
    output logic              out_valid,
    output logic [CFT_QW-1:0] out_quo [LANES],
    output logic [PW-1:0]     out_pay
);

    logic              vld_reg [CFT_QW];
    logic [31:0]       den_reg [CFT_QW];
    logic [PW-1:0]     pay_reg [CFT_QW];
    logic [31:0]       rem_reg [CFT_QW][LANES];
    logic [CFT_QW-1:0] low_reg [CFT_QW][LANES];
    logic [CFT_QW-1:0] quo_reg [CFT_QW][LANES];

    for (genvar k = 0; k < CFT_QW; k++) begin : g_step
        logic              vld_q;
        logic [31:0]       den_q;
        logic [PW-1:0]     pay_q;
        logic [31:0]       rem_q [LANES];
        logic [CFT_QW-1:0] low_q [LANES];
        logic [CFT_QW-1:0] quo_q [LANES];

        if (k == 0) begin : g_first
            assign vld_q = in_valid;
            assign den_q = in_den;
            assign pay_q = in_pay;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_q[l] = 32'(in_num[l] >> CFT_QW);
                assign low_q[l] = in_num[l][CFT_QW-1:0];
                assign quo_q[l] = '0;
            end
        end else begin : g_next
            assign vld_q = vld_reg[k-1];
            assign den_q = den_reg[k-1];
            assign pay_q = pay_reg[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_q[l] = rem_reg[k-1][l];
                assign low_q[l] = low_reg[k-1][l];
                assign quo_q[l] = quo_reg[k-1][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_q;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_work
            logic [32:0] trial;
            assign trial = {rem_q[l], low_q[l][CFT_QW-1-k]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (trial >= {1'b0, den_q})
                    begin
                        rem_reg[k][l] <= 32'(trial - {1'b0, den_q});
                        quo_reg[k][l] <= {quo_q[l][CFT_QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k][l] <= trial[31:0];
                        quo_reg[k][l] <= {quo_q[l][CFT_QW-2:0], 1'b0};
                    end
                    low_reg[k][l] <= low_q[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_q;
                pay_reg[k] <= pay_q;
            end
        end
    end

    assign out_valid = vld_reg[CFT_QW-1];
    assign out_pay   = pay_reg[CFT_QW-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_quo[l] = quo_reg[CFT_QW-1][l];
    end

endmodule

`default_nettype wire

@@ sv/crosswind_frame_transform_unit.sv @@
`default_nettype none

// Channel | Dir | Payload
// --------+-----+-------------------------------------------------------
// req     | in  | action, center_x/y/z, vin_x/y/z (signed Q16.16)
// rsp     | out | vout_x/y/z (signed Q16.16, saturated)
//
// Fully pipelined: one item accepted per cycle while rsp is not stalled.
// Most of the depth lies in the two square roots (32 stages each) and the two
// dividers (31 stages each) that normalize the x and y axes.
// Reset (rst_n, async, active low) clears only the valid bits.
// A stall on rsp freezes the whole pipeline; req.ready drops with it,
// so nothing is lost or repeated.
module crosswind_frame_transform_unit import cft_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cft_in_if.sink    req,
    cft_out_if.source rsp
);

    // Item plus x axis (Q2.30)
    typedef struct packed {
        cft_item_t          item;
        logic signed [31:0] r0x;
        logic signed [31:0] r0y;
        logic signed [31:0] r0z;
    } ax_t;

    localparam int ItemW = $bits(cft_item_t);
    localparam int AxW   = $bits(ax_t);

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [38:0] x);
        if (x > 39'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (x < -39'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    logic en;
    logic rsp_valid_reg;
    logic signed [31:0] rsp_x_reg, rsp_y_reg, rsp_z_reg;

    // Whole pipeline moves unless the output is held
    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;

    // ---------------------------------------------------------------- S0 capture
    logic      s0_vld_reg;
    cft_item_t s0_item_reg;

    // ---------------------------------------------------------------- S1 |c_i|^2
    logic        s1_vld_reg;
    cft_item_t   s1_item_reg;
    logic [63:0] s1_sq_reg [3];

    // ---------------------------------------------------------------- S2 sum
    logic        s2_vld_reg;
    cft_item_t   s2_item_reg;
    logic [63:0] s2_sum_reg;

    // first root
    logic        rt1_vld;
    logic [31:0] rt1_root;
    logic [ItemW-1:0] rt1_pay;
    cft_item_t   rt1_item;

    // ---------------------------------------------------------------- S3 div setup
    logic        s3_vld_reg;
    cft_item_t   s3_item_reg;
    logic [63:0] s3_num_reg [3];
    logic [31:0] s3_den_reg;

    logic              dv1_vld;
    logic [CFT_QW-1:0] dv1_quo [3];
    logic [ItemW-1:0]  dv1_pay;
    cft_item_t         dv1_item;

    // ---------------------------------------------------------------- S4 x axis
    logic  s4_vld_reg;
    ax_t   s4_ax_reg;

    // ---------------------------------------------------------------- S5, S6 y raw norm^2
    logic               s5_vld_reg;
    ax_t                s5_ax_reg;
    logic signed [63:0] s5_sq_reg [2];

    logic        s6_vld_reg;
    ax_t         s6_ax_reg;
    logic [63:0] s6_sum_reg;

    logic           rt2_vld;
    logic [31:0]    rt2_root;
    logic [AxW-1:0] rt2_pay;
    ax_t            rt2_ax;

    // ---------------------------------------------------------------- S7 div setup
    logic        s7_vld_reg;
    ax_t         s7_ax_reg;
    logic [63:0] s7_num_reg [2];
    logic [31:0] s7_den_reg;

    logic              dv2_vld;
    logic [CFT_QW-1:0] dv2_quo [2];
    logic [AxW-1:0]    dv2_pay;
    ax_t               dv2_ax;

    // ---------------------------------------------------------------- S8 y axis
    logic               s8_vld_reg;
    ax_t                s8_ax_reg;
    logic signed [31:0] s8_r1x_reg, s8_r1y_reg;

    // ---------------------------------------------------------------- S9 z axis products
    logic               s9_vld_reg;
    ax_t                s9_ax_reg;
    logic signed [31:0] s9_r1x_reg, s9_r1y_reg;
    logic signed [63:0] s9_p_reg [4];

    // ---------------------------------------------------------------- S10 frame done
    logic               s10_vld_reg;
    ax_t                s10_ax_reg;
    logic signed [31:0] s10_r1x_reg, s10_r1y_reg;
    logic signed [31:0] s10_r2_reg [3];

    // ---------------------------------------------------------------- S11 operand select
    logic               s11_vld_reg;
    cft_item_t          s11_item_reg;
    logic signed [31:0] s11_m_reg [3][3];
    logic signed [32:0] s11_w_reg [3];

    // ---------------------------------------------------------------- S12 products
    logic               s12_vld_reg;
    cft_item_t          s12_item_reg;
    logic signed [64:0] s12_p_reg [3][3];

    // ---------------------------------------------------------------- S13 dot
    logic               s13_vld_reg;
    cft_item_t          s13_item_reg;
    logic signed [37:0] s13_dot_reg [3];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s8_vld_reg    <= 1'b0;
            s9_vld_reg    <= 1'b0;
            s10_vld_reg   <= 1'b0;
            s11_vld_reg   <= 1'b0;
            s12_vld_reg   <= 1'b0;
            s13_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg    <= req.valid;
            s1_vld_reg    <= s0_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= rt1_vld;
            s4_vld_reg    <= dv1_vld;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= rt2_vld;
            s8_vld_reg    <= dv2_vld;
            s9_vld_reg    <= s8_vld_reg;
            s10_vld_reg   <= s9_vld_reg;
            s11_vld_reg   <= s10_vld_reg;
            s12_vld_reg   <= s11_vld_reg;
            s13_vld_reg   <= s12_vld_reg;
            rsp_valid_reg <= s13_vld_reg;
        end
    end

    // S0..S2: squared norm of c
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg.action   <= req.action;
            s0_item_reg.center_x <= req.center_x;
            s0_item_reg.center_y <= req.center_y;
            s0_item_reg.center_z <= req.center_z;
            s0_item_reg.vin_x    <= req.vin_x;
            s0_item_reg.vin_y    <= req.vin_y;
            s0_item_reg.vin_z    <= req.vin_z;

            s1_item_reg  <= s0_item_reg;
            s1_sq_reg[0] <= mag32(s0_item_reg.center_x) * mag32(s0_item_reg.center_x);
            s1_sq_reg[1] <= mag32(s0_item_reg.center_y) * mag32(s0_item_reg.center_y);
            s1_sq_reg[2] <= mag32(s0_item_reg.center_z) * mag32(s0_item_reg.center_z);

            s2_item_reg <= s1_item_reg;
            s2_sum_reg  <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
        end
    end

    cft_isqrt #(.PW(ItemW)) u_root_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .in_rad    (s2_sum_reg),
        .in_pay    (s2_item_reg),
        .out_valid (rt1_vld),
        .out_root  (rt1_root),
        .out_pay   (rt1_pay)
    );
    assign rt1_item = cft_item_t'(rt1_pay);

    // S3: numerators |c_i| * 2^30 + n/2, norm floored at one LSB
    logic [31:0] den1;
    assign den1 = (rt1_root == '0) ? 32'd1 : rt1_root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_item_reg   <= rt1_item;
            s3_den_reg    <= den1;
            s3_num_reg[0] <= ({32'd0, mag32(rt1_item.center_x)} << 30) + {33'd0, den1[31:1]};
            s3_num_reg[1] <= ({32'd0, mag32(rt1_item.center_y)} << 30) + {33'd0, den1[31:1]};
            s3_num_reg[2] <= ({32'd0, mag32(rt1_item.center_z)} << 30) + {33'd0, den1[31:1]};
        end
    end

    cft_div #(.PW(ItemW), .LANES(3)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_num    (s3_num_reg),
        .in_den    (s3_den_reg),
        .in_pay    (s3_item_reg),
        .out_valid (dv1_vld),
        .out_quo   (dv1_quo),
        .out_pay   (dv1_pay)
    );
    assign dv1_item = cft_item_t'(dv1_pay);

    // S4: x axis is -c/|c|; S5, S6: norm^2 of (-x.y, x.x, 0)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ax_reg.item <= dv1_item;
            s4_ax_reg.r0x  <= dv1_item.center_x[31] ? $signed({1'b0, dv1_quo[0]})
                                                    : -$signed({1'b0, dv1_quo[0]});
            s4_ax_reg.r0y  <= dv1_item.center_y[31] ? $signed({1'b0, dv1_quo[1]})
                                                    : -$signed({1'b0, dv1_quo[1]});
            s4_ax_reg.r0z  <= dv1_item.center_z[31] ? $signed({1'b0, dv1_quo[2]})
                                                    : -$signed({1'b0, dv1_quo[2]});

            s5_ax_reg    <= s4_ax_reg;
            s5_sq_reg[0] <= s4_ax_reg.r0y * s4_ax_reg.r0y;
            s5_sq_reg[1] <= s4_ax_reg.r0x * s4_ax_reg.r0x;

            s6_ax_reg  <= s5_ax_reg;
            s6_sum_reg <= 64'(s5_sq_reg[0]) + 64'(s5_sq_reg[1]);
        end
    end

    cft_isqrt #(.PW(AxW)) u_root_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_vld_reg),
        .in_rad    (s6_sum_reg),
        .in_pay    (s6_ax_reg),
        .out_valid (rt2_vld),
        .out_root  (rt2_root),
        .out_pay   (rt2_pay)
    );
    assign rt2_ax = ax_t'(rt2_pay);

    // S7: the third raw component is zero, so its quotient is always zero
    logic [31:0] den2;
    assign den2 = (rt2_root == '0) ? 32'd1 : rt2_root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_ax_reg     <= rt2_ax;
            s7_den_reg    <= den2;
            s7_num_reg[0] <= ({32'd0, mag32(rt2_ax.r0y)} << 30) + {33'd0, den2[31:1]};
            s7_num_reg[1] <= ({32'd0, mag32(rt2_ax.r0x)} << 30) + {33'd0, den2[31:1]};
        end
    end

    cft_div #(.PW(AxW), .LANES(2)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_vld_reg),
        .in_num    (s7_num_reg),
        .in_den    (s7_den_reg),
        .in_pay    (s7_ax_reg),
        .out_valid (dv2_vld),
        .out_quo   (dv2_quo),
        .out_pay   (dv2_pay)
    );
    assign dv2_ax = ax_t'(dv2_pay);

    // S8: y axis signs (raw x is -r0y, raw y is r0x)
    // S9, S10: z axis = x cross y with y.z = 0, rounded from Q4.60
    logic signed [65:0] r2_sum [3];
    assign r2_sum[0] = 66'sd536870912 - 66'(s9_p_reg[0]);
    assign r2_sum[1] = 66'sd536870912 + 66'(s9_p_reg[1]);
    assign r2_sum[2] = 66'sd536870912 + 66'(s9_p_reg[2]) - 66'(s9_p_reg[3]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_ax_reg  <= dv2_ax;
            s8_r1x_reg <= (dv2_ax.r0y > 0) ? -$signed({1'b0, dv2_quo[0]})
                                           : $signed({1'b0, dv2_quo[0]});
            s8_r1y_reg <= dv2_ax.r0x[31] ? -$signed({1'b0, dv2_quo[1]})
                                         : $signed({1'b0, dv2_quo[1]});

            s9_ax_reg   <= s8_ax_reg;
            s9_r1x_reg  <= s8_r1x_reg;
            s9_r1y_reg  <= s8_r1y_reg;
            s9_p_reg[0] <= s8_ax_reg.r0z * s8_r1y_reg;
            s9_p_reg[1] <= s8_ax_reg.r0z * s8_r1x_reg;
            s9_p_reg[2] <= s8_ax_reg.r0x * s8_r1y_reg;
            s9_p_reg[3] <= s8_ax_reg.r0y * s8_r1x_reg;

            s10_ax_reg  <= s9_ax_reg;
            s10_r1x_reg <= s9_r1x_reg;
            s10_r1y_reg <= s9_r1y_reg;
            for (int i = 0; i < 3; i++)
            begin
                s10_r2_reg[i] <= 32'(r2_sum[i] >>> 30);
            end
        end
    end

    // S11: rows for into-frame actions, columns for out-of-frame ones
    logic signed [31:0] rows [3][3];
    logic signed [31:0] m_sel [3][3];
    logic signed [32:0] w_sel [3];
    logic               use_cols;
    cft_item_t          it10;

    assign it10 = s10_ax_reg.item;

    always_comb
    begin
        rows[0][0] = s10_ax_reg.r0x;
        rows[0][1] = s10_ax_reg.r0y;
        rows[0][2] = s10_ax_reg.r0z;
        rows[1][0] = s10_r1x_reg;
        rows[1][1] = s10_r1y_reg;
        rows[1][2] = '0;
        rows[2][0] = s10_r2_reg[0];
        rows[2][1] = s10_r2_reg[1];
        rows[2][2] = s10_r2_reg[2];

        unique case (cft_action_t'(it10.action))
            ACT_ROT_IN:
            begin
                use_cols = 1'b0;
                w_sel[0] = 33'(it10.vin_x);
                w_sel[1] = 33'(it10.vin_y);
                w_sel[2] = 33'(it10.vin_z);
            end
            ACT_PT_IN:
            begin
                use_cols = 1'b0;
                w_sel[0] = 33'(it10.vin_x) - 33'(it10.center_x);
                w_sel[1] = 33'(it10.vin_y) - 33'(it10.center_y);
                w_sel[2] = 33'(it10.vin_z) - 33'(it10.center_z);
            end
            ACT_ROT_OUT, ACT_PT_OUT:
            begin
                use_cols = 1'b1;
                w_sel[0] = 33'(it10.vin_x);
                w_sel[1] = 33'(it10.vin_y);
                w_sel[2] = 33'(it10.vin_z);
            end
            default:
            begin
                use_cols = 1'b0;
                w_sel[0] = 33'(it10.vin_x);
                w_sel[1] = 33'(it10.vin_y);
                w_sel[2] = 33'(it10.vin_z);
            end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_sel[i][k] = use_cols ? rows[k][i] : rows[i][k];
            end
        end
    end

    // S11..S13: select, multiply, reduce with round to Q16.16
    logic signed [66:0] dot_sum [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_sum[i] = 67'sd536870912 + 67'(s12_p_reg[i][0]) + 67'(s12_p_reg[i][1])
                       + 67'(s12_p_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_item_reg <= it10;
            s11_m_reg    <= m_sel;
            s11_w_reg    <= w_sel;

            s12_item_reg <= s11_item_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s12_p_reg[i][k] <= s11_m_reg[i][k] * s11_w_reg[k];
                end
            end

            s13_item_reg <= s12_item_reg;
            for (int i = 0; i < 3; i++)
            begin
                s13_dot_reg[i] <= 38'(dot_sum[i] >>> 30);
            end
        end
    end

    // S14: add centre for point-out, saturate into the output register
    logic signed [38:0] fin [3];
    always_comb
    begin
        if (cft_action_t'(s13_item_reg.action) == ACT_PT_OUT)
        begin
            fin[0] = 39'(s13_dot_reg[0]) + 39'(s13_item_reg.center_x);
            fin[1] = 39'(s13_dot_reg[1]) + 39'(s13_item_reg.center_y);
            fin[2] = 39'(s13_dot_reg[2]) + 39'(s13_item_reg.center_z);
        end
        else
        begin
            fin[0] = 39'(s13_dot_reg[0]);
            fin[1] = 39'(s13_dot_reg[1]);
            fin[2] = 39'(s13_dot_reg[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_x_reg <= sat32(fin[0]);
            rsp_y_reg <= sat32(fin[1]);
            rsp_z_reg <= sat32(fin[2]);
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.vout_x = rsp_x_reg;
    assign rsp.vout_y = rsp_y_reg;
    assign rsp.vout_z = rsp_z_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
    import cft_pkg::*;

    // Rotation rows are Q2.30; products stay well inside 128 bits.
    typedef logic signed [127:0] wide_t;

    logic clk;
    logic rst_n;

    cft_in_if  req ();
    cft_out_if rsp ();

    crosswind_frame_transform_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Expected result of one item
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    vec_t vout_queue[$];
    int   mismatch_cnt;
    int   cycle_cnt;
    int   items_sent;

    // Idling control
    bit   calm_mode;        // no random gaps on either side
    bit   hold_rsp;         // long receiver hold-off
    int   hold_cycles;

    localparam int PIPE_LATENCY = 141;
    localparam int CYCLE_LIMIT  = 400000;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Floor integer square root of an unsigned 128-bit value
    function automatic logic [63:0] int_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] bitv;
        r    = '0;
        bitv = 128'd1 << 126;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r[63:0];
    endfunction

    // sign(a) * round_half_away(|a| * 2^30 / n)
    function automatic wide_t unit_comp(wide_t a, logic [63:0] n);
        logic [127:0] m;
        logic [127:0] q;
        m = (a < 0) ? -a : a;
        q = ((m << 30) + (n >> 1)) / n;
        return (a < 0) ? -wide_t'(q) : wide_t'(q);
    endfunction

    // floor((sum + 2^29) / 2^30); arithmetic shift is a floor
    function automatic wide_t round30(wide_t s);
        return (s + (wide_t'(1) <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(wide_t v);
        if (v > wide_t'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -wide_t'(64'sd2147483648))
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic vec_t frame_transform(cft_item_t it);
        wide_t c[3];
        wide_t v[3];
        wide_t d[3];
        wide_t r[3][3];
        wide_t res;
        logic [127:0] ssq;
        logic [63:0]  n;
        vec_t o;
        logic signed [31:0] comp[3];
        c[0] = it.center_x; c[1] = it.center_y; c[2] = it.center_z;
        v[0] = it.vin_x;    v[1] = it.vin_y;    v[2] = it.vin_z;
        // x axis: -c / |c|
        ssq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        n = int_sqrt(ssq);
        if (n < 1)
            n = 1;
        for (int i = 0; i < 3; i++)
            r[0][i] = -unit_comp(c[i], n);
        // y axis: z_hat cross x, normalized
        ssq = r[0][1] * r[0][1] + r[0][0] * r[0][0];
        n = int_sqrt(ssq);
        if (n < 1)
            n = 1;
        r[1][0] = unit_comp(-r[0][1], n);
        r[1][1] = unit_comp(r[0][0], n);
        r[1][2] = 0;
        // z axis: x cross y
        r[2][0] = round30(r[0][1] * r[1][2] - r[0][2] * r[1][1]);
        r[2][1] = round30(r[0][2] * r[1][0] - r[0][0] * r[1][2]);
        r[2][2] = round30(r[0][0] * r[1][1] - r[0][1] * r[1][0]);
        for (int k = 0; k < 3; k++)
            d[k] = v[k] - c[k];
        for (int i = 0; i < 3; i++)
        begin
            case (cft_action_t'(it.action))
                ACT_ROT_IN:
                    res = round30(r[i][0] * v[0] + r[i][1] * v[1] + r[i][2] * v[2]);
                ACT_PT_IN:
                    res = round30(r[i][0] * d[0] + r[i][1] * d[1] + r[i][2] * d[2]);
                ACT_ROT_OUT:
                    res = round30(r[0][i] * v[0] + r[1][i] * v[1] + r[2][i] * v[2]);
                default:
                    res = round30(r[0][i] * v[0] + r[1][i] * v[1] + r[2][i] * v[2])
                          + c[i];
            endcase
            comp[i] = clamp32(res);
        end
        o.x = comp[0];
        o.y = comp[1];
        o.z = comp[2];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    task automatic send_item(cft_item_t it);
        // random gap before offering the item
        while (!calm_mode && $urandom_range(99) < 27)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.action   <= it.action;
        req.center_x <= it.center_x;
        req.center_y <= it.center_y;
        req.center_z <= it.center_z;
        req.vin_x    <= it.vin_x;
        req.vin_y    <= it.vin_y;
        req.vin_z    <= it.vin_z;
        do
            @(posedge clk);
        while (!req.ready);
        vout_queue.push_back(frame_transform(it));
        items_sent++;
        // valid stays high if another item follows; callers lower it when done
    endtask

    task automatic end_burst();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (vout_queue.size() != 0)
            @(posedge clk);
    endtask

    // Random Q16.16 value, biased toward edges and small magnitudes
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cft_item_t rand_item();
        cft_item_t it;
        it.action = 2'($urandom_range(3));
        it.center_x = rand_q();
        it.center_y = rand_q();
        it.center_z = rand_q();
        // vertical centre now and then
        if ($urandom_range(15) == 0)
        begin
            it.center_x = 0;
            it.center_y = 0;
        end
        it.vin_x = rand_q();
        it.vin_y = rand_q();
        it.vin_z = rand_q();
        return it;
    endfunction

    function automatic cft_item_t mk(cft_action_t a, int cx, int cy, int cz,
                                     int vx, int vy, int vz);
        cft_item_t it;
        it.action = a;
        it.center_x = cx; it.center_y = cy; it.center_z = cz;
        it.vin_x = vx;    it.vin_y = vy;    it.vin_z = vz;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every action with zero, vertical and ordinary centres, extremes, saturation, then tiny centres
    task automatic test_directed();
        cft_action_t a;
        for (int k = 0; k < 4; k++)
        begin
            a = cft_action_t'(k);
            // zero centre: rows all zero
            send_item(mk(a, 0, 0, 0, 32'h0001_0000, -32'h0002_0000, 32'h0003_0000));
            // vertical centre: y and z rows zero
            send_item(mk(a, 0, 0, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 7));
            // ordinary horizontal centre
            send_item(mk(a, 32'h0064_0000, -32'h0032_0000, 32'h0010_0000,
                         32'h0001_8000, 32'h0000_4000, -32'h0003_0000));
            // extremes, saturating
            send_item(mk(a, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
            send_item(mk(a, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        end
        // tiny centre, 1 LSB
        send_item(mk(ACT_PT_IN, 1, -1, 0, -1, -1, -1));
        send_item(mk(ACT_PT_OUT, -1, 0, 1, 32'hFFFF_FFFF, 0, 1));
        end_burst();
    endtask

    // Random items with random gaps, then a calm stretch
    task automatic test_random(int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            calm_mode = (i >= n_items - 120);
            send_item(rand_item());
        end
        calm_mode = 1'b0;
        end_burst();
    endtask

    // Receiver holds off long enough to fill the pipeline and stall req
    task automatic test_backpressure();
        hold_cycles = 400;
        hold_rsp    = 1'b1;
        calm_mode   = 1'b1;
        for (int i = 0; i < 200; i++)
            send_item(rand_item());
        calm_mode = 1'b0;
        end_burst();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_item(rand_item());
        end_burst();
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_item(rand_item());
        end_burst();
    endtask

    // ---------------------------------------------------------------
    // Receiver: ready pattern, with an optional long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_rsp)
        begin
            rsp.ready <= 1'b0;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else
                hold_rsp <= 1'b0;
        end
        else if (calm_mode)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(99) >= 27);
    end

    // Result checker
    always @(posedge clk)
    begin
        vec_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (vout_queue.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: %0d %0d %0d",
                             rsp.vout_x, rsp.vout_y, rsp.vout_z);
            end
            else
            begin
                e = vout_queue.pop_front();
                if (e.x !== rsp.vout_x || e.y !== rsp.vout_y || e.z !== rsp.vout_z)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("item mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 e.x, e.y, e.z, rsp.vout_x, rsp.vout_y, rsp.vout_z);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        items_sent   = 0;
        calm_mode    = 1'b0;
        hold_rsp     = 1'b0;
        hold_cycles  = 0;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.action   = ACT_ROT_IN;
        req.center_x = '0;
        req.center_y = '0;
        req.center_z = '0;
        req.vin_x    = '0;
        req.vin_y    = '0;
        req.vin_z    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(500);

        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (mismatch_cnt == 0 && vout_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cft_pkg.sv
sv/cft_in_if.sv
sv/cft_out_if.sv
sv/cft_isqrt.sv
sv/cft_div.sv
sv/crosswind_frame_transform_unit.sv
dv/tb_top.sv
